/* rtl/tcw_pkg.sv */
// Package for the text console character writer.
// Holds the screen geometry, request and character codes, and the result record.
// No dependencies.
package tcw_pkg;

    // Screen geometry.
    localparam int COLS     = 80;
    localparam int ROWS     = 25;
    localparam int NCELLS   = COLS * ROWS;
    localparam int MOVE_CNT = (ROWS - 1) * COLS;
    localparam int ADDR_W   = $clog2(NCELLS);

    // Field widths.
    localparam int CELL_W  = 16;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int REQ_W   = 2;
    localparam int COLOR_W = 4;
    localparam int CFG_IDX_W = 2;

    // Request kinds.
    localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // Characters with special handling.
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    // Configuration register indexes and reset values.
    localparam logic [CFG_IDX_W-1:0] CFG_FG_COLOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAB_SIZE = 2'd2;

    localparam logic [COLOR_W-1:0] FG_RESET  = 4'd7;
    localparam logic [COLOR_W-1:0] BG_RESET  = 4'd0;
    localparam logic [COLOR_W-1:0] TAB_RESET = 4'd4;

    // One result beat, packed so that cell_value sits in the lowest bits.
    typedef struct packed {
        logic              overflow;
        logic [ROW_W-1:0]  cursor_row;
        logic [COL_W-1:0]  cursor_col;
        logic [CELL_W-1:0] cell_value;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

/* rtl/text_console_char_writer.sv */
// Text console character writer. A stream of requests writes characters into
// an 80 by 25 cell screen store, reads cells back or clears the screen; every
// request beat yields exactly one result beat with the cursor after the item.
// Requests enter on the s_ channel, results leave on the m_ channel, and the
// colors and tab width are set through the cfg_wr_ port. The user is to write
// them only while the block idles; the block itself does not enforce it.
// An ordinary character, a newline that does not scroll, or a request that
// changes nothing is finished at its accept edge and its result is valid in
// the next cycle. A read does one memory read, and a tab writes its spaces
// one by one. A newline on the last row scrolls the store through the single
// memory port pair, and a clear zeroes every cell; s_tready is low meanwhile.
// After reset the block runs a clearing pass over all COLS*ROWS cells with
// s_tready low; configuration writes are taken during it.
// A two-beat result buffer decouples m_tready: a new item is accepted while
// a result waits, and while idle s_tready drops only when both slots are full.
// Depends on tcw_pkg, tcw_engine and tcw_out_fifo.
module text_console_char_writer (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [7:0] char_code, [18:8] cell_index, rest zero
    input  logic [23:0]                       s_tdata,
    // [1:0] req_type
    input  logic [tcw_pkg::REQ_W-1:0]         s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] cell_value, [22:16] cursor_col, [27:23] cursor_row, [28] overflow
    output logic [31:0]                       m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [tcw_pkg::COLOR_W-1:0]       cfg_wr_data
);
    import tcw_pkg::*;

    logic [COLOR_W-1:0] fg_reg;
    logic [COLOR_W-1:0] bg_reg;
    logic [COLOR_W-1:0] tab_reg;

    logic    fifo_full;
    logic    push;
    result_t push_data;
    result_t out_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg  <= FG_RESET;
            bg_reg  <= BG_RESET;
            tab_reg <= TAB_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_FG_COLOR: fg_reg  <= cfg_wr_data;
                CFG_BG_COLOR: bg_reg  <= cfg_wr_data;
                CFG_TAB_SIZE: tab_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    tcw_engine u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .req_type   (s_tuser),
        .char_code  (s_tdata[7:0]),
        .cell_index (s_tdata[18:8]),
        .fg_color   (fg_reg),
        .bg_color   (bg_reg),
        .tab_size   (tab_reg),
        .fifo_full  (fifo_full),
        .push       (push),
        .push_data  (push_data)
    );

    tcw_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {(32 - RESULT_W)'(0), out_data};

endmodule

/* rtl/tcw_out_fifo.sv */
// Two-entry result buffer between the console engine and the master port.
// Lets the engine finish an item while the previous result still waits.
// Depends on tcw_pkg.
module tcw_out_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  tcw_pkg::result_t push_data,
    output logic            full,
    output logic            out_valid,
    input  logic            out_ready,
    output tcw_pkg::result_t out_data
);
    import tcw_pkg::*;

    result_t     head_reg, head_next;
    result_t     tail_reg, tail_next;
    logic [1:0]  count_reg, count_next;
    logic        pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign full      = (count_reg == 2'd2);
    assign out_data  = head_reg;

    always_comb begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push && !pop) begin
            if (count_reg == 2'd0) begin
                head_next = push_data;
            end else begin
                tail_next = push_data;
            end
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            head_next  = tail_reg;
            count_next = count_reg - 2'd1;
        end else if (pop && push) begin
            if (count_reg == 2'd1) begin
                head_next = push_data;
            end else begin
                head_next = tail_reg;
                tail_next = push_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

/* rtl/tcw_engine.sv */
// Console engine: the screen cell memory, the cursor and the sequencer that
// walks the memory for tabs, scrolls, clears and the post-reset clearing pass.
// Depends on tcw_pkg.
module tcw_engine (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tcw_pkg::REQ_W-1:0]     req_type,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::IDX_W-1:0]     cell_index,
    input  logic [tcw_pkg::COLOR_W-1:0]   fg_color,
    input  logic [tcw_pkg::COLOR_W-1:0]   bg_color,
    input  logic [tcw_pkg::COLOR_W-1:0]   tab_size,
    input  logic                          fifo_full,
    output logic                          push,
    output tcw_pkg::result_t              push_data
);
    import tcw_pkg::*;

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_TAB    = 6'b000100,
        ST_READ   = 6'b001000,
        ST_SCROLL = 6'b010000,
        ST_ZERO   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [COL_W-1:0]    x_reg, x_next;
    logic [ROW_W-1:0]    y_reg, y_next;
    logic [ADDR_W-1:0]   cnt_reg, cnt_next;
    logic [COLOR_W-1:0]  rem_reg, rem_next;
    logic                in_range_reg, in_range_next;
    logic                pend_reg, pend_next;
    logic [ADDR_W-1:0]   wa_reg, wa_next;

    logic [CELL_W-1:0]   screen_mem [NCELLS];
    logic [CELL_W-1:0]   rd_data_reg;

    logic                mem_we;
    logic [ADDR_W-1:0]   mem_waddr;
    logic [CELL_W-1:0]   mem_wdata;
    logic                rd_en;
    logic [ADDR_W-1:0]   rd_addr;

    logic                accept;
    logic [ADDR_W-1:0]   cur_addr;
    logic [CELL_W-1:0]   attr_cell;
    logic                at_line_end;
    logic [CELL_W-1:0]   res_value;
    logic                res_overflow;

    assign in_ready    = (state_reg == ST_IDLE) && !fifo_full;
    assign accept      = in_valid && in_ready;
    assign cur_addr    = ADDR_W'(ADDR_W'(y_reg) * ADDR_W'(COLS) + ADDR_W'(x_reg));
    assign attr_cell   = {bg_color, fg_color, 8'h00};
    assign at_line_end = (x_reg >= COL_W'(COLS));

    always_comb begin
        state_next    = state_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        cnt_next      = cnt_reg;
        rem_next      = rem_reg;
        in_range_next = in_range_reg;
        pend_next     = 1'b0;
        wa_next       = wa_reg;
        mem_we        = 1'b0;
        mem_waddr     = cur_addr;
        mem_wdata     = '0;
        rd_en         = 1'b0;
        rd_addr       = cell_index[ADDR_W-1:0];
        push          = 1'b0;
        res_value     = '0;
        res_overflow  = 1'b0;

        case (state_reg)
            ST_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                if (cnt_reg == ADDR_W'(NCELLS - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    case (req_type)
                        REQ_WRITE: begin
                            if (char_code == CH_NEWLINE) begin
                                x_next = '0;
                                if (y_reg == ROW_W'(ROWS - 1)) begin
                                    cnt_next   = '0;
                                    state_next = ST_SCROLL;
                                end else begin
                                    y_next = y_reg + ROW_W'(1);
                                    push   = 1'b1;
                                end
                            end else if (char_code == CH_TAB) begin
                                if (tab_size == '0) begin
                                    push = 1'b1;
                                end else if (at_line_end) begin
                                    push         = 1'b1;
                                    res_overflow = 1'b1;
                                end else begin
                                    rem_next   = tab_size;
                                    state_next = ST_TAB;
                                end
                            end else begin
                                push = 1'b1;
                                if (at_line_end) begin
                                    res_overflow = 1'b1;
                                end else begin
                                    mem_we    = 1'b1;
                                    mem_wdata = attr_cell | CELL_W'(char_code);
                                    x_next    = x_reg + COL_W'(1);
                                end
                            end
                        end
                        REQ_READ: begin
                            rd_en         = 1'b1;
                            in_range_next = (32'(cell_index) < NCELLS);
                            state_next    = ST_READ;
                        end
                        REQ_CLEAR: begin
                            x_next     = '0;
                            y_next     = '0;
                            cnt_next   = '0;
                            state_next = ST_ZERO;
                        end
                        default: begin
                            push = 1'b1;
                        end
                    endcase
                end
            end
            ST_TAB: begin
                // One space per cycle until the count runs out or the line ends.
                mem_we    = 1'b1;
                mem_wdata = attr_cell | CELL_W'(CH_SPACE);
                x_next    = x_reg + COL_W'(1);
                rem_next  = rem_reg - COLOR_W'(1);
                if (rem_reg == COLOR_W'(1) || x_next == COL_W'(COLS)) begin
                    push         = 1'b1;
                    res_overflow = (rem_reg != COLOR_W'(1));
                    state_next   = ST_IDLE;
                end
            end
            ST_READ: begin
                push       = 1'b1;
                res_value  = in_range_reg ? rd_data_reg : '0;
                state_next = ST_IDLE;
            end
            ST_SCROLL: begin
                // Read one row ahead, write the data back in the next cycle.
                mem_we    = pend_reg;
                mem_waddr = wa_reg;
                mem_wdata = rd_data_reg;
                if (cnt_reg == ADDR_W'(MOVE_CNT)) begin
                    state_next = ST_ZERO;
                end else begin
                    rd_en     = 1'b1;
                    rd_addr   = cnt_reg + ADDR_W'(COLS);
                    pend_next = 1'b1;
                    wa_next   = cnt_reg;
                    cnt_next  = cnt_reg + ADDR_W'(1);
                end
            end
            ST_ZERO: begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg;
                if (cnt_reg == ADDR_W'(NCELLS - 1)) begin
                    push       = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        push_data.cell_value = res_value;
        push_data.cursor_col = x_next;
        push_data.cursor_row = y_next;
        push_data.overflow   = res_overflow;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            x_reg     <= '0;
            y_reg     <= '0;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            x_reg     <= x_next;
            y_reg     <= y_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
        rem_reg      <= rem_next;
        in_range_reg <= in_range_next;
        wa_reg       <= wa_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rd_data_reg <= screen_mem[rd_addr];
        end
    end

endmodule

/* tb/sv/text_console_char_writer_tb.sv */
// Self-checking testbench for text_console_char_writer: request beats in, one status beat out.
// A scoreboard shadow of the screen store, cursor and color registers predicts every result.
// Depends on tcw_pkg and the RTL of the console writer.
module text_console_char_writer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int HOLD_CYCLES = 500;
    localparam int SEG_ITEMS   = 137;
    // Scrolls and clears walk the whole screen store and dominate the run time.
    localparam int CYCLE_LIMIT = 2_000_000;

    typedef struct packed {
        logic [REQ_W-1:0]  req;
        logic [CHAR_W-1:0] ch;
        logic [IDX_W-1:0]  idx;
    } console_req_t;

    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_tvalid     = 1'b0;
    logic                 s_tready;
    logic [23:0]          s_tdata      = '0;
    logic [REQ_W-1:0]     s_tuser      = '0;
    logic                 m_tvalid;
    logic                 m_tready     = 1'b0;
    logic [31:0]          m_tdata;
    logic                 cfg_wr_en    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_wr_index = '0;
    logic [COLOR_W-1:0]   cfg_wr_data  = '0;

    // Shadow of the block's state and registers.
    logic [CELL_W-1:0]  screen_shadow [NCELLS];
    logic [COL_W-1:0]   cur_x;
    logic [ROW_W-1:0]   cur_y;
    logic [COLOR_W-1:0] fg_q  = FG_RESET;
    logic [COLOR_W-1:0] bg_q  = BG_RESET;
    logic [COLOR_W-1:0] tab_q = TAB_RESET;

    console_req_t pending_reqs [$];
    result_t      console_results_q [$];
    console_req_t cur_req;
    int           n_queued   = 0;
    int           n_accepted = 0;
    int           n_fail     = 0;
    int           snd_idle_pct = 0;
    int           rcv_idle_pct = 0;
    bit           hold_req   = 1'b0;
    bit           hold_done  = 1'b0;
    int           hold_left  = 0;
    int           cycle_cnt  = 0;

    text_console_char_writer dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #5 aclk = ~aclk;

    // Stores one glyph at the cursor; returns 1 when it falls past the line end.
    function automatic logic place_glyph(input logic [CHAR_W-1:0] c);
        if (cur_x >= COLS) begin
            return 1'b1;
        end
        screen_shadow[int'(cur_y) * COLS + int'(cur_x)] = {bg_q, fg_q, c};
        cur_x++;
        return 1'b0;
    endfunction

    task automatic apply_console_request(input console_req_t r);
        result_t res;
        logic    dropped;
        int      k;
        res     = '0;
        dropped = 1'b0;
        case (r.req)
            REQ_WRITE: begin
                if (r.ch == CH_NEWLINE) begin
                    cur_x = '0;
                    if (cur_y >= ROWS - 1) begin
                        for (k = 0; k < MOVE_CNT; k++) begin
                            screen_shadow[k] = screen_shadow[k + COLS];
                        end
                        for (k = MOVE_CNT; k < NCELLS; k++) begin
                            screen_shadow[k] = '0;
                        end
                        cur_y = ROW_W'(ROWS - 1);
                    end else begin
                        cur_y++;
                    end
                end else if (r.ch == CH_TAB) begin
                    for (k = 0; k < int'(tab_q); k++) begin
                        if (place_glyph(CH_SPACE)) begin
                            dropped = 1'b1;
                        end
                    end
                end else begin
                    dropped = place_glyph(r.ch);
                end
            end
            REQ_READ: begin
                if (r.idx < NCELLS) begin
                    res.cell_value = screen_shadow[r.idx];
                end
            end
            REQ_CLEAR: begin
                for (k = 0; k < NCELLS; k++) begin
                    screen_shadow[k] = '0;
                end
                cur_x = '0;
                cur_y = '0;
            end
            default: ;
        endcase
        res.cursor_col = cur_x;
        res.cursor_row = cur_y;
        res.overflow   = dropped;
        console_results_q.push_back(res);
    endtask

    task automatic queue_req(input logic [REQ_W-1:0] req, input int unsigned ch,
                             input int unsigned idx);
        console_req_t r;
        r.req = req;
        r.ch  = ch[CHAR_W-1:0];
        r.idx = idx[IDX_W-1:0];
        pending_reqs.push_back(r);
        n_queued++;
    endtask

    // Mostly cells near the left edge, where short lines leave text behind.
    function automatic int unsigned random_cell_index();
        if ($urandom_range(3) == 0) begin
            return $urandom_range(0, 2047);
        end
        return $urandom_range(0, ROWS - 1) * COLS + $urandom_range(0, 15);
    endfunction

    task automatic queue_read(input int unsigned idx);
        queue_req(REQ_READ, $urandom_range(0, 255), idx);
    endtask

    task automatic queue_char(input int unsigned ch);
        queue_req(REQ_WRITE, ch, $urandom_range(0, 2047));
    endtask

    task automatic wait_idle();
        while (n_accepted != n_queued || console_results_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (10) @(posedge aclk);
    endtask

    task automatic set_config(input logic [COLOR_W-1:0] fg, input logic [COLOR_W-1:0] bg,
                              input logic [COLOR_W-1:0] tab);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= CFG_FG_COLOR;
        cfg_wr_data  <= fg;
        @(posedge aclk);
        cfg_wr_index <= CFG_BG_COLOR;
        cfg_wr_data  <= bg;
        @(posedge aclk);
        cfg_wr_index <= CFG_TAB_SIZE;
        cfg_wr_data  <= tab;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        fg_q  = fg;
        bg_q  = bg;
        tab_q = tab;
    endtask

    // Builds traffic: text lines, read bursts, newline bursts, tabs, clears, unused requests.
    task automatic queue_traffic(input int n_items);
        int made;
        int kind;
        int len;
        int k;
        int sel;
        made = 0;
        while (made < n_items) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                len = ($urandom_range(4) == 0) ? $urandom_range(60, 95) : $urandom_range(0, 8);
                for (k = 0; k < len; k++) begin
                    sel = $urandom_range(19);
                    if (sel == 0) begin
                        queue_char(CH_TAB);
                    end else if (sel == 1) begin
                        queue_read(random_cell_index());
                    end else begin
                        queue_char($urandom_range(0, 255));
                    end
                end
                queue_char(CH_NEWLINE);
                made += len + 1;
            end else if (kind < 70) begin
                len = $urandom_range(1, 6);
                for (k = 0; k < len; k++) begin
                    queue_read(random_cell_index());
                end
                made += len;
            end else if (kind < 78) begin
                len = $urandom_range(5, 26);
                for (k = 0; k < len; k++) begin
                    queue_char(CH_NEWLINE);
                end
                made += len;
            end else if (kind < 88) begin
                len = $urandom_range(1, 8);
                for (k = 0; k < len; k++) begin
                    queue_char(CH_TAB);
                end
                made += len;
            end else if (kind < 90) begin
                queue_req(REQ_CLEAR, $urandom_range(0, 255), $urandom_range(0, 2047));
                made++;
            end else if (kind < 92) begin
                queue_req(REQ_UNUSED, $urandom_range(0, 255), $urandom_range(0, 2047));
                made++;
            end else begin
                queue_req(REQ_W'($urandom_range(0, 2)), $urandom_range(0, 255),
                          $urandom_range(0, 2047));
                made++;
            end
        end
    endtask

    always @(posedge aclk) begin : sender
        console_req_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_console_request(cur_req);
                n_accepted++;
            end
            if (!s_tvalid || s_tready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
                    nxt      = pending_reqs.pop_front();
                    cur_req  = nxt;
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, nxt.idx, nxt.ch};
                    s_tuser  <= nxt.req;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // The long hold-off lets the result buffer fill so that s_tready must drop.
    always @(posedge aclk) begin : receiver
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin : result_mon
        result_t got;
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = result_t'(m_tdata[RESULT_W-1:0]);
            if (console_results_q.size() == 0) begin
                $error("result beat with nothing expected, m_tdata = %h", m_tdata);
                n_fail++;
            end else begin
                want = console_results_q.pop_front();
                if (got.cell_value !== want.cell_value) begin
                    $error("cell_value: expected %h, got %h", want.cell_value, got.cell_value);
                    n_fail++;
                end
                if (got.cursor_col !== want.cursor_col) begin
                    $error("cursor_col: expected %0d, got %0d", want.cursor_col, got.cursor_col);
                    n_fail++;
                end
                if (got.cursor_row !== want.cursor_row) begin
                    $error("cursor_row: expected %0d, got %0d", want.cursor_row, got.cursor_row);
                    n_fail++;
                end
                if (got.overflow !== want.overflow) begin
                    $error("overflow: expected %0b, got %0b", want.overflow, got.overflow);
                    n_fail++;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("Some tests failed");
        $finish;
    end

    initial begin : stimulus
        logic [COLOR_W-1:0] seg_fg [6];
        logic [COLOR_W-1:0] seg_bg [6];
        logic [COLOR_W-1:0] seg_tab [6];
        int s;
        int k;

        for (k = 0; k < NCELLS; k++) begin
            screen_shadow[k] = '0;
        end
        cur_x = '0;
        cur_y = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset colors: characters, byte extremes, a tab, reads, unused request, newline, clear.
        queue_char(8'h41);
        queue_char(8'h00);
        queue_char(8'hFF);
        queue_char(CH_TAB);
        queue_read(0);
        queue_read(2);
        queue_read(5);
        queue_read(NCELLS - 1);
        queue_read(NCELLS);
        queue_read(2047);
        queue_req(REQ_UNUSED, 8'hFF, 2047);
        queue_char(CH_NEWLINE);
        queue_char(8'h42);
        queue_read(COLS);
        queue_req(REQ_CLEAR, 8'h00, 0);
        queue_read(COLS);
        wait_idle();

        // Widest tab runs the cursor into the line end; the last tab and a character drop.
        set_config(4'hF, 4'hF, 4'hF);
        for (k = 0; k < 6; k++) begin
            queue_char(CH_TAB);
        end
        queue_char(8'h5A);
        queue_read(COLS - 1);
        queue_read(0);
        queue_char(CH_NEWLINE);
        wait_idle();

        // A tab of width zero writes nothing.
        set_config(4'h0, 4'h0, 4'h0);
        queue_char(CH_TAB);
        queue_char(8'h7E);
        queue_read(COLS);
        wait_idle();

        seg_fg[0] = COLOR_W'($urandom_range(0, 15)); seg_bg[0] = COLOR_W'($urandom_range(0, 15));
        seg_tab[0] = COLOR_W'($urandom_range(1, 15));
        seg_fg[1] = 4'h0; seg_bg[1] = 4'h0; seg_tab[1] = 4'h0;
        seg_fg[2] = 4'hF; seg_bg[2] = 4'hF; seg_tab[2] = 4'hF;
        seg_fg[3] = COLOR_W'($urandom_range(0, 15)); seg_bg[3] = COLOR_W'($urandom_range(0, 15));
        seg_tab[3] = COLOR_W'($urandom_range(0, 15));
        seg_fg[4] = 4'h0; seg_bg[4] = 4'hF; seg_tab[4] = 4'h8;
        seg_fg[5] = 4'hF; seg_bg[5] = 4'h0; seg_tab[5] = COLOR_W'($urandom_range(1, 15));

        for (s = 0; s < 6; s++) begin
            case (s / 2)
                0: begin snd_idle_pct = 9;  rcv_idle_pct = 87; end
                1: begin snd_idle_pct = 87; rcv_idle_pct = 9;  end
                default: begin snd_idle_pct = 0; rcv_idle_pct = 0; end
            endcase
            set_config(seg_fg[s], seg_bg[s], seg_tab[s]);
            // Make sure the bottom row is reached and scrolled early on.
            if (s == 0) begin
                for (k = 0; k < 26; k++) begin
                    queue_char(CH_NEWLINE);
                end
            end
            if (s == 4) begin
                hold_req = 1'b1;
            end
            queue_traffic(SEG_ITEMS);
            wait_idle();
        end

        repeat (20) @(posedge aclk);
        if (n_fail == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/tcw_pkg.sv
rtl/tcw_out_fifo.sv
rtl/tcw_engine.sv
rtl/text_console_char_writer.sv
tb/sv/text_console_char_writer_tb.sv
